[rtl/edfq_pkg.sv]
// Shared types, codes and defaults for the EDF deadline task queue.
package edfq_pkg;

  // Default queue depth
  localparam int unsigned MAX_ACTIVE_DEF = 16;

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ACT_W    = 5;
  localparam int unsigned TOTAL_W  = 16;

  // Command codes
  localparam logic [FUNC_W-1:0] FN_RELEASE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_COMPLETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_MONITOR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MONITOR   = 3'd4;

  // Saturation limit of the completion and overdue totals
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // Operations of the shared add / compare unit
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_LT  = 1'b1
  } edfq_alu_op_t;

  // One queue entry as stored in the table
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] deadline;
    logic [TICK_W-1:0] start;
    logic              started;
  } edfq_entry_t;

  // Accepted command
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [TICK_W-1:0] relative_deadline;
    logic [TICK_W-1:0] now;
  } edfq_cmd_t;

  // Result of one command
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                running_valid;
    logic [ID_W-1:0]     running_id;
    logic [TICK_W-1:0]   running_start;
    logic                overdue_valid;
    logic [ID_W-1:0]     overdue_id;
    logic [TICK_W-1:0]   finish_time;
    logic [ACT_W-1:0]    active_count;
    logic [TOTAL_W-1:0]  completed_count;
    logic [TOTAL_W-1:0]  overdue_count;
  } edfq_res_t;

endpackage

[rtl/edfq_alu.sv]
// Shared 32-bit add / unsigned less-than unit used by the queue sequencer.
module edfq_alu (
  input  edfq_pkg::edfq_alu_op_t        op,
  input  logic [edfq_pkg::TICK_W-1:0]   a,
  input  logic [edfq_pkg::TICK_W-1:0]   b,
  output logic [edfq_pkg::TICK_W-1:0]   y,
  output logic                          lt
);

  logic [edfq_pkg::TICK_W-1:0] b_op;
  logic                        cin;
  logic [edfq_pkg::TICK_W:0]   sum;

  // One adder: a + b, or a + ~b + 1 for the compare
  assign cin  = (op == edfq_pkg::ALU_LT);
  assign b_op = cin ? ~b : b;
  assign sum  = {1'b0, a} + {1'b0, b_op} + {{edfq_pkg::TICK_W{1'b0}}, cin};

  // No carry out of a - b means a < b
  assign y  = sum[edfq_pkg::TICK_W-1:0];
  assign lt = cin & ~sum[edfq_pkg::TICK_W];

endmodule

[rtl/edfq_seq.sv]
// Queue sequencer: sorted entry table, scan / shift passes and head bookkeeping.
module edfq_seq #(
  parameter int unsigned MAX_ACTIVE = edfq_pkg::MAX_ACTIVE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  edfq_pkg::edfq_cmd_t cmd,
  output logic                busy,
  output logic                res_valid,
  input  logic                res_ready,
  output edfq_pkg::edfq_res_t res
);

  localparam int unsigned AW = $clog2(MAX_ACTIVE);
  localparam int unsigned CW = $clog2(MAX_ACTIVE + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ACTIVE);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_ADD     = 10'b00_0000_0010,
    S_INS_RD  = 10'b00_0000_0100,
    S_INS_EV  = 10'b00_0000_1000,
    S_INS_WR  = 10'b00_0001_0000,
    S_DEL_RD  = 10'b00_0010_0000,
    S_DEL_EV  = 10'b00_0100_0000,
    S_HEAD_RD = 10'b00_1000_0000,
    S_HEAD_EV = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } edfq_state_t;

  edfq_state_t state_r, state_nxt;

  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [edfq_pkg::TOTAL_W-1:0]     done_r, done_nxt;
  logic [edfq_pkg::TOTAL_W-1:0]     late_r, late_nxt;
  logic [CW-1:0]                    k_r, k_nxt;
  logic [edfq_pkg::FUNC_W-1:0]      func_r, func_nxt;
  logic [edfq_pkg::ID_W-1:0]        tid_r, tid_nxt;
  logic [edfq_pkg::TICK_W-1:0]      now_r, now_nxt;
  logic [edfq_pkg::TICK_W-1:0]      dl_r, dl_nxt;
  logic [edfq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [edfq_pkg::TICK_W-1:0]      finish_r, finish_nxt;
  logic                             ov_valid_r, ov_valid_nxt;
  logic [edfq_pkg::ID_W-1:0]        ov_id_r, ov_id_nxt;
  logic                             found_r, found_nxt;
  logic                             del_late_r, del_late_nxt;
  logic                             checked_r, checked_nxt;
  logic [edfq_pkg::ID_W-1:0]        head_id_r, head_id_nxt;
  logic [edfq_pkg::TICK_W-1:0]      head_start_r, head_start_nxt;

  // Entry table, one write and one registered read port
  edfq_pkg::edfq_entry_t mem [MAX_ACTIVE];
  edfq_pkg::edfq_entry_t rd_data_r;
  edfq_pkg::edfq_entry_t mem_wd;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  edfq_pkg::edfq_alu_op_t      alu_op;
  logic [edfq_pkg::TICK_W-1:0] alu_a;
  logic [edfq_pkg::TICK_W-1:0] alu_b;
  logic [edfq_pkg::TICK_W-1:0] alu_y;
  logic                        alu_lt;

  logic [CW-1:0]   k_inc;
  logic [CW-1:0]   k_dec;
  logic            found_now;
  logic [CW+4:0]   cnt_ext;

  edfq_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .lt (alu_lt)
  );

  assign k_inc     = k_r + ONE_C;
  assign k_dec     = k_r - ONE_C;
  assign found_now = found_r | del_late_r | (rd_data_r.id == tid_r);

  // Sequencer next state and table accesses
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    done_nxt       = done_r;
    late_nxt       = late_r;
    k_nxt          = k_r;
    func_nxt       = func_r;
    tid_nxt        = tid_r;
    now_nxt        = now_r;
    dl_nxt         = dl_r;
    status_nxt     = status_r;
    finish_nxt     = finish_r;
    ov_valid_nxt   = ov_valid_r;
    ov_id_nxt      = ov_id_r;
    found_nxt      = found_r;
    del_late_nxt   = del_late_r;
    checked_nxt    = checked_r;
    head_id_nxt    = head_id_r;
    head_start_nxt = head_start_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = rd_data_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    alu_op         = edfq_pkg::ALU_LT;
    alu_a          = rd_data_r.deadline;
    alu_b          = now_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt     = cmd.func;
          tid_nxt      = cmd.task_id;
          now_nxt      = cmd.now;
          dl_nxt       = cmd.relative_deadline;
          finish_nxt   = '0;
          ov_valid_nxt = 1'b0;
          ov_id_nxt    = '0;
          found_nxt    = 1'b0;
          del_late_nxt = 1'b0;
          checked_nxt  = 1'b0;
          k_nxt        = '0;
          status_nxt   = edfq_pkg::ST_MONITOR;
          unique case (cmd.func)
            edfq_pkg::FN_RELEASE: begin
              if (cnt_r == MAX_C) begin
                status_nxt = edfq_pkg::ST_FULL;
                state_nxt  = S_HEAD_RD;
              end else begin
                state_nxt = S_ADD;
              end
            end
            edfq_pkg::FN_COMPLETE: begin
              status_nxt = edfq_pkg::ST_NOTFOUND;
              state_nxt  = (cnt_r == '0) ? S_HEAD_RD : S_DEL_RD;
            end
            edfq_pkg::FN_MONITOR: begin
              state_nxt = S_HEAD_RD;
            end
            default: begin
              // unused code: report only, no overdue check
              checked_nxt = 1'b1;
              state_nxt   = S_HEAD_RD;
            end
          endcase
        end
      end

      // Absolute deadline = now + relative deadline
      S_ADD: begin
        alu_op    = edfq_pkg::ALU_ADD;
        alu_a     = now_r;
        alu_b     = dl_r;
        dl_nxt    = alu_y;
        k_nxt     = cnt_r;
        state_nxt = S_INS_RD;
      end

      // Walk down from the tail, shifting later deadlines up one slot
      S_INS_RD: begin
        if (k_r == '0) begin
          state_nxt = S_INS_WR;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = k_dec[AW-1:0];
          state_nxt = S_INS_EV;
        end
      end

      S_INS_EV: begin
        alu_a = dl_r;
        alu_b = rd_data_r.deadline;
        if (alu_lt) begin
          mem_we    = 1'b1;
          mem_wa    = k_r[AW-1:0];
          mem_wd    = rd_data_r;
          k_nxt     = k_dec;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      // Drop the new task into the gap; a new head starts now
      S_INS_WR: begin
        mem_we     = 1'b1;
        mem_wa     = k_r[AW-1:0];
        mem_wd     = '{id: tid_r, deadline: dl_r, start: now_r, started: (k_r == '0)};
        cnt_nxt    = cnt_r + ONE_C;
        status_nxt = edfq_pkg::ST_INSERTED;
        state_nxt  = S_HEAD_RD;
      end

      // Forward pass: find the entry, then pull later entries down one slot
      S_DEL_RD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r[AW-1:0];
        state_nxt = S_DEL_EV;
      end

      S_DEL_EV: begin
        if (found_r) begin
          mem_we = 1'b1;
          mem_wa = k_dec[AW-1:0];
          mem_wd = rd_data_r;
        end
        found_nxt = found_now;
        if (k_inc == cnt_r) begin
          state_nxt = S_HEAD_RD;
          if (found_now) begin
            cnt_nxt = cnt_r - ONE_C;
            if (del_late_r) begin
              late_nxt = (late_r == edfq_pkg::TOTAL_MAX) ? late_r : late_r + 16'd1;
            end else begin
              done_nxt   = (done_r == edfq_pkg::TOTAL_MAX) ? done_r : done_r + 16'd1;
              finish_nxt = now_r;
              status_nxt = edfq_pkg::ST_COMPLETED;
            end
          end
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_DEL_RD;
        end
      end

      S_HEAD_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = S_HEAD_EV;
        end
      end

      // Mark the head running, then drop it once if its deadline has passed
      S_HEAD_EV: begin
        head_id_nxt    = rd_data_r.id;
        head_start_nxt = rd_data_r.started ? rd_data_r.start : now_r;
        if (!rd_data_r.started) begin
          mem_we         = 1'b1;
          mem_wa         = '0;
          mem_wd         = rd_data_r;
          mem_wd.started = 1'b1;
          mem_wd.start   = now_r;
        end
        alu_a     = rd_data_r.deadline;
        alu_b     = now_r;
        state_nxt = S_DONE;
        if (!checked_r) begin
          checked_nxt = 1'b1;
          if (alu_lt) begin
            ov_valid_nxt = 1'b1;
            ov_id_nxt    = rd_data_r.id;
            del_late_nxt = 1'b1;
            found_nxt    = 1'b0;
            k_nxt        = '0;
            state_nxt    = S_DEL_RD;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= '0;
      late_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      late_r  <= late_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    func_r       <= func_nxt;
    tid_r        <= tid_nxt;
    now_r        <= now_nxt;
    dl_r         <= dl_nxt;
    status_r     <= status_nxt;
    finish_r     <= finish_nxt;
    ov_valid_r   <= ov_valid_nxt;
    ov_id_r      <= ov_id_nxt;
    found_r      <= found_nxt;
    del_late_r   <= del_late_nxt;
    checked_r    <= checked_nxt;
    head_id_r    <= head_id_nxt;
    head_start_r <= head_start_nxt;
  end

  // Entry table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result
  assign cnt_ext   = {5'b0, cnt_r};
  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status          = status_r;
    res.running_valid   = (cnt_r != '0);
    res.running_id      = (cnt_r != '0) ? head_id_r : '0;
    res.running_start   = (cnt_r != '0) ? head_start_r : '0;
    res.overdue_valid   = ov_valid_r;
    res.overdue_id      = ov_id_r;
    res.finish_time     = finish_r;
    res.active_count    = cnt_ext[4:0];
    res.completed_count = done_r;
    res.overdue_count   = late_r;
  end

  // The table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C)
    else $error("entry count above table depth");

  // An insert only lands in a table with room
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR) |-> (cnt_r < MAX_C))
    else $error("insert into full table");

  // Removal pass stays inside the filled part of the table
  a_del_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_RD) |-> (k_r < cnt_r))
    else $error("removal pass beyond entry count");

  // The count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + ONE_C ||
              cnt_r == $past(cnt_r) - ONE_C))
    else $error("entry count jumped");

  // A taken result returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_ready) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle");

endmodule

[rtl/edf_deadline_task_queue_top.sv]
// Top level of the EDF deadline task queue: input capture and result register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid / in_stall   | func, task_id, relative_deadline, now
//  out_    | output    | out_valid / out_stall | status, running and overdue task, counts
//
// A release reads the entries behind its insertion point, a complete reads the
// whole table, and an overdue drop adds one more full scan. Each entry read goes
// through the single read port of the entry table and its registered read data.
// Reset (rst_n low, synchronous) empties the queue and clears both totals; table
// contents stay undefined until written, so no clearing pass runs.
// in_stall is high while a command is at work; out_stall holds the result and,
// while a finished result waits behind it, the next command too.
module edf_deadline_task_queue_top #(
  parameter int unsigned MAX_ACTIVE = edfq_pkg::MAX_ACTIVE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [edfq_pkg::FUNC_W-1:0]          in_func,
  input  logic [edfq_pkg::ID_W-1:0]            in_task_id,
  input  logic [edfq_pkg::TICK_W-1:0]          in_relative_deadline,
  input  logic [edfq_pkg::TICK_W-1:0]          in_now,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [edfq_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_running_valid,
  output logic [edfq_pkg::ID_W-1:0]            out_running_id,
  output logic [edfq_pkg::TICK_W-1:0]          out_running_start,
  output logic                                 out_overdue_valid,
  output logic [edfq_pkg::ID_W-1:0]            out_overdue_id,
  output logic [edfq_pkg::TICK_W-1:0]          out_finish_time,
  output logic [edfq_pkg::ACT_W-1:0]           out_active_count,
  output logic [edfq_pkg::TOTAL_W-1:0]         out_completed_count,
  output logic [edfq_pkg::TOTAL_W-1:0]         out_overdue_count
);

  edfq_pkg::edfq_cmd_t cmd_r, cmd_nxt;
  logic                cmd_pend_r, cmd_pend_nxt;
  edfq_pkg::edfq_res_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;

  edfq_pkg::edfq_res_t seq_res;
  logic                seq_busy;
  logic                seq_res_valid;
  logic                res_ready;
  logic                in_take;

  edfq_seq #(
    .MAX_ACTIVE (MAX_ACTIVE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd_pend_r),
    .cmd       (cmd_r),
    .busy      (seq_busy),
    .res_valid (seq_res_valid),
    .res_ready (res_ready),
    .res       (seq_res)
  );

  // Hold off new beats while a command waits or runs
  assign in_stall  = cmd_pend_r | seq_busy;
  assign in_take   = in_valid & ~in_stall;
  assign res_ready = ~out_valid_r | ~out_stall;

  // Capture the command beat, release it once the sequencer takes it
  always_comb begin
    cmd_nxt      = cmd_r;
    cmd_pend_nxt = cmd_pend_r;
    if (in_take) begin
      cmd_nxt      = '{func: in_func, task_id: in_task_id,
                       relative_deadline: in_relative_deadline, now: in_now};
      cmd_pend_nxt = 1'b1;
    end else if (cmd_pend_r && !seq_busy) begin
      cmd_pend_nxt = 1'b0;
    end
  end

  // Result register: load a finished result, drop it when taken
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (seq_res_valid && res_ready) begin
      res_nxt       = seq_res;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_pend_r  <= cmd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_running_valid   = res_r.running_valid;
  assign out_running_id      = res_r.running_id;
  assign out_running_start   = res_r.running_start;
  assign out_overdue_valid   = res_r.overdue_valid;
  assign out_overdue_id      = res_r.overdue_id;
  assign out_finish_time     = res_r.finish_time;
  assign out_active_count    = res_r.active_count;
  assign out_completed_count = res_r.completed_count;
  assign out_overdue_count   = res_r.overdue_count;

endmodule
